>>> design/rss_pkg.sv
// Shared types and constants for the running sample statistics block.
package rss_pkg;

    localparam int DATA_W       = 32;
    localparam int ACC_W        = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int SAMPLE_SHIFT = DATA_W - SAMPLE_WIDTH;
    localparam int KIND_W       = 2;
    localparam int MODE_W       = 2;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_STEPS    = ACC_W / 2;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_COUNTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NUMERIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GROUP   = 2'd2;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  sample;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]  sample_total;
        logic [DATA_W-1:0]  smallest;
        logic [DATA_W-1:0]  largest;
        logic [DATA_W-1:0]  most_recent;
        logic [ACC_W-1:0]   total;
        logic [ACC_W-1:0]   squares_total;
        logic [DATA_W-1:0]  mean;
        logic [DATA_W-1:0]  raw_value;
    } t_snapshot;

endpackage

>>> design/rss_front.sv
// Front end: accepts items, decodes the kind, sign-extends the sample, queues them.
module rss_front import rss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [DATA_W-1:0]   i_sample,
    output logic                o_q_valid,
    output t_item               o_q_item,
    input  logic                i_q_pop
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;
    t_item              new_item;
    logic signed [DATA_W-1:0] shifted;

    always_comb begin
        unique case (i_kind)
            KIND_RECORD: new_item.op = OP_RECORD;
            KIND_CLEAR:  new_item.op = OP_CLEAR;
            default:     new_item.op = OP_QUERY;
        endcase
        shifted         = $signed(i_sample) <<< SAMPLE_SHIFT;
        new_item.sample = shifted >>> SAMPLE_SHIFT;
    end

    assign o_in_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/rss_div.sv
// Unsigned 64-by-32 restoring divider, two quotient bits per cycle.
module rss_div import rss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ACC_W-1:0]    i_dividend,
    input  logic [DATA_W-1:0]   i_divisor,
    output logic                o_done,
    output logic [ACC_W-1:0]    o_quotient
);

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [ACC_W-1:0]       r_quo;
    logic [DATA_W-1:0]      r_rem;
    logic [DATA_W-1:0]      r_div;

    logic [DATA_W:0]        t1, t2, d_ext;
    logic                   ge1, ge2;
    logic [DATA_W-1:0]      rem1, rem2;
    logic [ACC_W-1:0]       quo1, quo2;

    always_comb begin
        d_ext = {1'b0, r_div};
        t1    = {r_rem, r_quo[ACC_W-1]};
        ge1   = (t1 >= d_ext);
        rem1  = ge1 ? DATA_W'(t1 - d_ext) : t1[DATA_W-1:0];
        quo1  = {r_quo[ACC_W-2:0], ge1};
        t2    = {rem1, quo1[ACC_W-1]};
        ge2   = (t2 >= d_ext);
        rem2  = ge2 ? DATA_W'(t2 - d_ext) : t2[DATA_W-1:0];
        quo2  = {quo1[ACC_W-2:0], ge2};
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= quo2;
                r_rem <= rem2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> design/rss_back.sv
// Back end: applies queued items to the statistics and builds each snapshot.
module rss_back import rss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    input  logic                i_cfg_valid,
    input  logic [MODE_W-1:0]   i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_snapshot           o_snap
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_UPDATE,
        S_PREP,
        S_DIVIDE,
        S_EMIT
    } t_state;

    localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    t_state             r_state;
    logic [MODE_W-1:0]  r_mode;
    t_op                r_op;
    logic [DATA_W-1:0]  r_s;
    logic [DATA_W-1:0]  r_mag;
    logic [ACC_W-1:0]   r_sq;
    logic               r_neg;
    logic [DATA_W-1:0]  r_mean;
    logic               r_out_valid;
    t_snapshot          r_snap;

    // statistics
    logic [DATA_W-1:0]  r_cnt,  n_cnt;
    logic               r_minv, n_minv;
    logic [DATA_W-1:0]  r_min,  n_min;
    logic [DATA_W-1:0]  r_max,  n_max;
    logic [ACC_W-1:0]   r_sum,  n_sum;
    logic [ACC_W-1:0]   r_sqs,  n_sqs;
    logic [DATA_W-1:0]  r_last, n_last;
    logic [DATA_W-1:0]  r_raw,  n_raw;

    logic [ACC_W:0]     sum_ext;
    logic [ACC_W:0]     sqs_ext;
    logic [DATA_W-1:0]  in_mag;
    logic               need_div;
    logic               div_start;
    logic               div_done;
    logic [ACC_W-1:0]   div_quo;
    logic [ACC_W-1:0]   dividend;
    logic [DATA_W-1:0]  mean_clamped;
    logic               out_free;
    t_snapshot          snap;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_snap      = r_snap;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign in_mag = i_q_item.sample[DATA_W-1] ? DATA_W'(-i_q_item.sample) : i_q_item.sample;

    always_comb begin
        n_cnt  = r_cnt;
        n_minv = r_minv;
        n_min  = r_min;
        n_max  = r_max;
        n_sum  = r_sum;
        n_sqs  = r_sqs;
        n_last = r_last;
        n_raw  = r_raw;
        sum_ext = {r_sum[ACC_W-1], r_sum}
                + {{(ACC_W-DATA_W+1){r_s[DATA_W-1]}}, r_s};
        sqs_ext = {1'b0, r_sqs} + {1'b0, r_sq};
        case (r_op)
            OP_CLEAR: begin
                n_cnt  = '0;
                n_minv = 1'b0;
                n_min  = '0;
                n_max  = '0;
                n_sum  = '0;
                n_sqs  = '0;
                n_last = '0;
                n_raw  = '0;
            end
            OP_RECORD: begin
                n_raw = r_s;
                if (r_mode == MODE_COUNTER) begin
                    n_last = (r_last != INT_MAX) ? r_last + 1'b1 : r_last;
                    n_max  = n_last;
                end else begin
                    // signed clamp on overflow of the 65-bit sum
                    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
                        n_sum = sum_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                               : {1'b0, {(ACC_W-1){1'b1}}};
                    end else begin
                        n_sum = sum_ext[ACC_W-1:0];
                    end
                    n_sqs  = sqs_ext[ACC_W] ? '1 : sqs_ext[ACC_W-1:0];
                    n_cnt  = (r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;
                    n_last = r_s;
                    n_minv = 1'b1;
                    if (!r_minv || ($signed(r_min) > $signed(r_s))) begin
                        n_min = r_s;
                    end
                    if ($signed(r_max) < $signed(r_s)) begin
                        n_max = r_s;
                    end
                end
            end
            default: ;
        endcase
    end

    assign need_div  = (r_mode == MODE_NUMERIC) && (r_cnt != '0);
    assign div_start = (r_state == S_PREP) && need_div;
    assign dividend  = r_sum[ACC_W-1] ? ACC_W'(-r_sum) : r_sum;

    rss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        if (r_neg) begin
            if ((|div_quo[ACC_W-1:DATA_W]) || (div_quo[DATA_W-1] && (|div_quo[DATA_W-2:0]))) begin
                mean_clamped = INT_MIN;
            end else begin
                mean_clamped = DATA_W'(-div_quo[DATA_W-1:0]);
            end
        end else begin
            mean_clamped = (|div_quo[ACC_W-1:DATA_W-1]) ? INT_MAX : div_quo[DATA_W-1:0];
        end
    end

    always_comb begin
        snap = '0;
        case (r_mode)
            MODE_COUNTER: begin
                snap.sample_total = r_last[DATA_W-1] ? '0 : r_last;
                snap.smallest     = r_min;
                snap.largest      = r_max;
                snap.most_recent  = r_last;
                snap.total        = r_sum;
                snap.raw_value    = r_raw;
            end
            MODE_NUMERIC: begin
                snap.sample_total  = r_cnt;
                snap.smallest      = r_min;
                snap.largest       = r_max;
                snap.most_recent   = r_last;
                snap.total         = r_sum;
                snap.squares_total = r_sqs;
                snap.mean          = r_mean;
                snap.raw_value     = r_raw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_NUMERIC;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_minv      <= 1'b0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_sqs       <= '0;
            r_last      <= '0;
            r_raw       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op    <= i_q_item.op;
                        r_s     <= i_q_item.sample;
                        r_mag   <= in_mag;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_sq    <= ACC_W'(r_mag) * ACC_W'(r_mag);
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_cnt   <= n_cnt;
                    r_minv  <= n_minv;
                    r_min   <= n_min;
                    r_max   <= n_max;
                    r_sum   <= n_sum;
                    r_sqs   <= n_sqs;
                    r_last  <= n_last;
                    r_raw   <= n_raw;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg <= r_sum[ACC_W-1];
                    if (need_div) begin
                        r_state <= S_DIVIDE;
                    end else begin
                        r_mean  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_DIVIDE: begin
                    if (div_done) begin
                        r_mean  <= mean_clamped;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_snap      <= snap;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/running_sample_statistics.sv
// Top level of the running sample statistics monitor.
// Path (back end free): each item goes through the SQUARE, UPDATE, PREP and EMIT states before the result
// is valid; in numeric mode with a nonzero count, DIVIDE (divider at 2 bits/cycle) lies between PREP and EMIT.
// The back end works on one item at a time, and the input queue holds two more.
// Reset (synchronous, active low) clears all statistics, empties the queue and sets
// monitor_kind to numeric mode; no clearing pass is needed.
module running_sample_statistics import rss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [DATA_W-1:0]   i_sample,
    // configuration write channel (monitor_kind)
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MODE_W-1:0]   i_cfg_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DATA_W-1:0]   o_sample_total,
    output logic [DATA_W-1:0]   o_smallest,
    output logic [DATA_W-1:0]   o_largest,
    output logic [DATA_W-1:0]   o_most_recent,
    output logic [ACC_W-1:0]    o_total,
    output logic [ACC_W-1:0]    o_squares_total,
    output logic [DATA_W-1:0]   o_mean,
    output logic [DATA_W-1:0]   o_raw_value
);

    logic       q_valid;
    t_item      q_item;
    logic       q_pop;
    t_snapshot  snap;

    // The user must issue config writes only while the block is idle; the block does not
    // enforce this, and the register takes every transfer.
    assign o_cfg_ready = 1'b1;

    // Front: decode kind (unknown code acts as a query), sign-extend the
    // sample from SAMPLE_WIDTH bits, and queue the item.
    rss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_sample   (i_sample),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    // Back: square, update, optional mean division, then the snapshot
    // lands in an output register that the downstream side drains.
    rss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_snap      (snap)
    );

    assign o_sample_total  = snap.sample_total;
    assign o_smallest      = snap.smallest;
    assign o_largest       = snap.largest;
    assign o_most_recent   = snap.most_recent;
    assign o_total         = snap.total;
    assign o_squares_total = snap.squares_total;
    assign o_mean          = snap.mean;
    assign o_raw_value     = snap.raw_value;

endmodule
